// ===== hdl/fdt_pkg.sv =====
// Shared constants and types for the fixed-point decimal text formatter.
`timescale 1ns / 1ps
package fdt_pkg;

  // Magnitude and BCD sizes: 2^127 needs 39 decimal digits
  localparam int MAG_W      = 128;
  localparam int NUM_DIGITS = 39;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int IDX_W      = $clog2(NUM_DIGITS + 1);
  localparam int CNT_W      = $clog2(MAG_W);

  // Scale field and its saturation limit
  localparam int          SCALE_W   = 6;
  localparam logic [5:0]  MAX_SCALE = 6'd38;

  // ASCII codes
  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_MINUS = 7'h2D;
  localparam logic [6:0] CHAR_DOT   = 7'h2E;

  // Commands from the sequencer to the shared BCD shift unit
  typedef struct packed {
    logic load;         // take a new magnitude, clear BCD
    logic step;         // one double-dabble correct-and-shift
    logic digit_shift;  // move BCD up by one digit
  } dab_ctrl_t;

endpackage

// ===== hdl/fixed_decimal_to_text.sv =====
// Top level: signed 128-bit scaled decimal value to ASCII text, one character per transfer.
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | in_tdata: value_high, value_low, scale
//  out_    | out | out_tvalid/out_tready| out_tdata: char_code; out_tlast: is_last
//
// Each value is accepted, then converted by double dabble in the shared BCD
// shift unit, one step per magnitude bit. The sequencer then passes the sign
// state (it sends '-' for a negative value), visits each of the 39 digit
// positions, skipped or sent, and sends the dot when scale is nonzero (up to
// 41 characters in all); output stalls can hold it. in_tready is high only
// while the sequencer is idle. The output register lets the next value enter
// while the last character still waits. rst_n is synchronous, active low, and
// clears the sequencer and the output valid.
`timescale 1ns / 1ps
module fixed_decimal_to_text (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [135:0] in_tdata,   // [63:0] value_high, [127:64] value_low, [133:128] scale
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [7:0]   out_tdata,  // [6:0] char_code
  output logic         out_tlast   // is_last
);
  import fdt_pkg::*;

  logic [63:0]        value_high;
  logic [63:0]        value_low;
  logic [SCALE_W-1:0] scale;
  logic [MAG_W-1:0]   raw;
  logic [MAG_W-1:0]   mag;
  logic               neg;
  dab_ctrl_t          dab;
  logic [3:0]         top_digit;
  logic [6:0]         char_code;

  assign value_high = in_tdata[63:0];
  assign value_low  = in_tdata[127:64];
  assign scale      = in_tdata[133:128];

  // Magnitude of the two's complement value
  assign raw = {value_high, value_low};
  assign neg = value_high[63];
  assign mag = neg ? (~raw + 1'b1) : raw;

  fdt_dabble u_dabble (
    .clk       (clk),
    .ctrl      (dab),
    .load_mag  (mag),
    .top_digit (top_digit)
  );

  fdt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_neg    (neg),
    .in_scale  (scale),
    .top_digit (top_digit),
    .dab       (dab),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_char  (char_code),
    .out_last  (out_tlast)
  );

  assign out_tdata = {1'b0, char_code};

endmodule

// ===== hdl/fdt_dabble.sv =====
// Shared BCD shift unit: bit-serial double dabble and digit shift-out.
`timescale 1ns / 1ps
module fdt_dabble (
  input  logic                             clk,
  input  fdt_pkg::dab_ctrl_t               ctrl,
  input  logic [fdt_pkg::MAG_W-1:0]        load_mag,
  output logic [3:0]                       top_digit
);
  import fdt_pkg::*;

  logic [MAG_W-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0] bcd_r, bcd_nxt;
  logic [BCD_W-1:0] bcd_adj;

  // Add three to every digit of five or more (digits are independent)
  always_comb begin
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (bcd_r[4*d +: 4] >= 4'd5) begin
        bcd_adj[4*d +: 4] = bcd_r[4*d +: 4] + 4'd3;
      end else begin
        bcd_adj[4*d +: 4] = bcd_r[4*d +: 4];
      end
    end
  end

  // Next state of the shift registers
  always_comb begin
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    if (ctrl.load) begin
      bin_nxt = load_mag;
      bcd_nxt = '0;
    end else if (ctrl.step) begin
      bin_nxt = {bin_r[MAG_W-2:0], 1'b0};
      bcd_nxt = {bcd_adj[BCD_W-2:0], bin_r[MAG_W-1]};
    end else if (ctrl.digit_shift) begin
      bcd_nxt = {bcd_r[BCD_W-5:0], 4'd0};
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign top_digit = bcd_r[BCD_W-1 -: 4];

endmodule

// ===== hdl/fdt_ctrl.sv =====
// Sequencer: conversion count, leading-zero skip, sign/dot/digit emission, output register.
`timescale 1ns / 1ps
module fdt_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_neg,
  input  logic [fdt_pkg::SCALE_W-1:0]   in_scale,
  input  logic [3:0]                    top_digit,
  output fdt_pkg::dab_ctrl_t            dab,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [6:0]                    out_char,
  output logic                          out_last
);
  import fdt_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SIGN = 2'd2;
  localparam logic [1:0] ST_DIG  = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [SCALE_W-1:0] sc_r, sc_nxt;
  logic               neg_r, neg_nxt;
  logic               started_r, started_nxt;
  logic               dot_done_r, dot_done_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [6:0]         out_char_r, out_char_nxt;
  logic               out_last_r, out_last_nxt;

  logic               emit_ok;
  logic               skip_zero;
  logic               want_dot;

  assign emit_ok   = !out_valid_r || out_ready;
  assign skip_zero = !started_r && (top_digit == 4'd0) &&
                     ({1'b0, idx_r} > ({1'b0, sc_r} + 7'd1));
  assign want_dot  = (sc_r != '0) && (idx_r == sc_r) && !dot_done_r;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    sc_nxt        = sc_r;
    neg_nxt       = neg_r;
    started_nxt   = started_r;
    dot_done_nxt  = dot_done_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    dab           = '0;
    in_ready      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          dab.load     = 1'b1;
          neg_nxt      = in_neg;
          sc_nxt       = (in_scale > MAX_SCALE) ? MAX_SCALE : in_scale;
          cnt_nxt      = '0;
          idx_nxt      = IDX_W'(NUM_DIGITS);
          started_nxt  = 1'b0;
          dot_done_nxt = 1'b0;
          state_nxt    = ST_CONV;
        end
      end
      ST_CONV: begin
        dab.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (&cnt_r) begin
          state_nxt = ST_SIGN;
        end
      end
      ST_SIGN: begin
        if (!neg_r) begin
          state_nxt = ST_DIG;
        end else if (emit_ok) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_DIG;
        end
      end
      ST_DIG: begin
        if (skip_zero) begin
          dab.digit_shift = 1'b1;
          idx_nxt         = idx_r - 1'b1;
        end else if (want_dot) begin
          if (emit_ok) begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = CHAR_DOT;
            out_last_nxt  = 1'b0;
            dot_done_nxt  = 1'b1;
            started_nxt   = 1'b1;
          end
        end else if (emit_ok) begin
          out_valid_nxt   = 1'b1;
          out_char_nxt    = CHAR_ZERO + {3'b000, top_digit};
          out_last_nxt    = (idx_r == IDX_W'(1));
          dab.digit_shift = 1'b1;
          idx_nxt         = idx_r - 1'b1;
          started_nxt     = 1'b1;
          if (idx_r == IDX_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and per-item registers
  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    idx_r      <= idx_nxt;
    sc_r       <= sc_nxt;
    neg_r      <= neg_nxt;
    started_r  <= started_nxt;
    dot_done_r <= dot_done_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

  // Digit index stays in range while digits are walked
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIG) |-> (idx_r != '0 && idx_r <= IDX_W'(NUM_DIGITS)))
    else $error("digit index out of range");

  // Leading-zero skip never eats into the scale+1 minimum digits
  a_skip_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIG && !started_r) |-> ({1'b0, idx_r} > {1'b0, sc_r}))
    else $error("leading-zero skip passed the decimal point");

  // Conversion runs its full bit count before text starts
  a_conv_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CONV && state_nxt == ST_SIGN) |-> (&cnt_r))
    else $error("conversion ended early");

  // A dot is only sent once a digit position has been reached
  a_dot_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIG && dot_done_r) |-> started_r)
    else $error("dot emitted before digits started");

endmodule
